// ===== src/hlcr_pkg.sv =====
// ----------------------------------------------------------------------------
// hlcr_pkg
// Shared types and codes of the layer crossfade resampler voice.
// ----------------------------------------------------------------------------
package hlcr_pkg;

	localparam int MAX_LAYERS = 4;
	localparam int LAYER_DEPTH = 16384;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_KILL  = 2'd3;

	localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [2:0] REG_PITCH_STEP  = 3'd1;
	localparam logic [2:0] REG_LENGTH0     = 3'd2;
	localparam logic [2:0] REG_LENGTH1     = 3'd3;
	localparam logic [2:0] REG_LENGTH2     = 3'd4;
	localparam logic [2:0] REG_LENGTH3     = 3'd5;
	localparam logic [2:0] REG_STEREO_MASK = 3'd6;

	localparam int HW = 24;

	typedef logic signed [15:0] sample_t;
	typedef logic signed [HW-1:0] herm_t;
	typedef sample_t taps_t [4];

	typedef struct packed {
		logic start;
		logic [15:0] frac;
	} herm_req_t;

endpackage

// ===== src/hlcr_sample_mem.sv =====
// ----------------------------------------------------------------------------
// hlcr_sample_mem
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hlcr_sample_mem
	import hlcr_pkg::*;
#(
	parameter int DEPTH = 131072,
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/hlcr_hermite.sv =====
// ----------------------------------------------------------------------------
// hlcr_hermite
// Four point cubic Hermite evaluation on one shared multiplier, Horner form,
// gives twice the interpolated value.
// ----------------------------------------------------------------------------
module hlcr_hermite
	import hlcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  herm_req_t req,
	input  taps_t     y,
	output logic      done,
	output herm_t     h
);

	typedef enum logic [1:0] {H_IDLE, H_MUL, H_ADD, H_FIN} hstate_t;

	hstate_t state_q;
	logic [1:0] step_q;
	herm_t c1_q, c2_q, t_q;
	sample_t y1_q;
	logic [15:0] f_q;
	logic signed [HW+16:0] p_q;
	logic signed [HW+16:0] p_rnd;
	herm_t addend;

	assign p_rnd = (p_q + (HW+17)'(32768)) >>> 16;

	always_comb begin
		unique case (step_q)
			2'd0:    addend = c2_q;
			2'd1:    addend = c1_q;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (req.start) begin
						c1_q <= HW'(y[2]) - HW'(y[0]);
						c2_q <= (HW'(y[0]) <<< 1) - HW'(y[1]) * HW'(5)
							+ (HW'(y[2]) <<< 2) - HW'(y[3]);
						t_q <= HW'(y[3]) - HW'(y[0]) + HW'(3) * (HW'(y[1]) - HW'(y[2]));
						y1_q <= y[1];
						f_q <= req.frac;
						step_q <= 2'd0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					p_q <= (HW+17)'(t_q * $signed({1'b0, f_q}));
					state_q <= H_ADD;
				end
				H_ADD: begin
					t_q <= HW'(p_rnd) + addend;
					step_q <= step_q + 2'd1;
					state_q <= (step_q == 2'd2) ? H_FIN : H_MUL;
				end
				H_FIN: begin
					h <= t_q + (HW'(y1_q) <<< 1);
					done <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

endmodule

// ===== src/hermite_layer_crossfade_resampler.sv =====
// ----------------------------------------------------------------------------
// hermite_layer_crossfade_resampler
// Sampler voice: cubic Hermite read of two adjacent layers with crossfade.
// ----------------------------------------------------------------------------
// One item at a time. Load, start, kill and idle ticks are done in the idle
// state. A playing tick walks two layer slots; for each active layer and
// channel it reads four taps from the sample memory and waits for the Hermite
// pass on a shared multiplier. Then crossfade, sum, gain and saturation run
// for the left and then the right channel, and the result goes to the output
// register once that is free. A tick where both layers are exhausted goes
// straight to the output with zeros. Inputs are taken while a finished result
// waits in the output register.
module hermite_layer_crossfade_resampler
	import hlcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  layer_sel,
	input  logic        channel_sel,
	input  logic [13:0] sample_addr,
	input  logic signed [15:0] sample_value,
	input  logic [15:0] dyn_pos,
	input  logic [15:0] gain,
	input  logic        release_over,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic        finished,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int DEPTH = MAX_LAYERS * 2 * LAYER_DEPTH;
	localparam int MW = $clog2(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_SLOT, S_READ, S_HERM, S_MUL, S_SUM, S_GAIN, S_SAT, S_OUT
	} state_t;

	state_t state_q;

	logic [2:0] layer_count_q;
	logic [19:0] pitch_step_q;
	logic [14:0] len_q [4];
	logic [3:0] stereo_mask_q;

	logic [29:0] phase_q;
	logic playing_q;

	logic [3:0] lay_q [2];
	logic [1:0] active_q, stereo_q;
	logic [14:0] last_q [2];
	logic [11:0] a_q;
	logic [13:0] pos_q;
	logic [15:0] f_q, gain_q;
	logic rel_q, upd_q;
	logic slot_q, ch_q, mix_ch_q;
	logic [2:0] tap_q;
	herm_t hl_q [2];
	herm_t hr_q [2];
	taps_t y_q;
	logic signed [HW+13:0] p0_q, p1_q;
	logic signed [HW+14:0] s_q;
	logic signed [HW+31:0] g_q;
	logic signed [15:0] res_l_q, res_r_q;
	logic res_fin_q;
	logic out_valid_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 3'd1;
			pitch_step_q  <= 20'd65536;
			for (int k = 0; k < 4; k++) len_q[k] <= '0;
			stereo_mask_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LAYER_COUNT: layer_count_q <= cfg_data[2:0];
				REG_PITCH_STEP:  pitch_step_q <= cfg_data;
				REG_LENGTH0:     len_q[0] <= cfg_data[14:0];
				REG_LENGTH1:     len_q[1] <= cfg_data[14:0];
				REG_LENGTH2:     len_q[2] <= cfg_data[14:0];
				REG_LENGTH3:     len_q[3] <= cfg_data[14:0];
				REG_STEREO_MASK: stereo_mask_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- decode
	logic accept;
	logic [2:0] n;
	logic [3:0] nm1, li, lj;
	logic [11:0] la;
	logic [14:0] len_i, len_j, pos15;
	logic act_i, act_j;

	function automatic logic [14:0] eff_len(input logic [3:0] l, input logic [14:0] lens [4]);
		logic [14:0] v;
		v = lens[l[1:0]];
		if (l >= 4'd4) begin
			v = '0;
		end else if (32'(v) > LAYER_DEPTH) begin
			v = 15'(LAYER_DEPTH);
		end
		return v;
	endfunction

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		n = (32'(layer_count_q) > MAX_LAYERS) ? 3'(MAX_LAYERS) : layer_count_q;
		nm1 = {1'b0, n} - 4'd1;
		li = dyn_pos[15:12];
		la = dyn_pos[11:0];
		if (li >= nm1) begin
			li = nm1;
			la = '0;
		end
		lj = (li == nm1) ? nm1 : li + 4'd1;
		len_i = eff_len(li, len_q);
		len_j = eff_len(lj, len_q);
		pos15 = {1'b0, phase_q[29:16]};
		act_i = (len_i != '0) && (pos15 + 15'd1 < len_i);
		act_j = (len_j != '0) && (pos15 + 15'd1 < len_j);
	end

	// ---------------------------------------------------------------- memory
	logic we;
	logic [MW-1:0] waddr, raddr;
	sample_t rdata;
	logic [14:0] last_c, p15, idx0, idx1, idx2, idx3, idx;

	assign we = accept && (command == CMD_LOAD) && (32'(layer_sel) < MAX_LAYERS)
		&& (32'(sample_addr) < LAYER_DEPTH);
	assign waddr = MW'(MW'({layer_sel, channel_sel}) * MW'(LAYER_DEPTH))
		+ MW'(sample_addr);

	always_comb begin
		last_c = last_q[slot_q];
		p15 = {1'b0, pos_q};
		idx0 = (pos_q == '0) ? '0 : p15 - 15'd1;
		idx1 = p15;
		idx2 = (p15 + 15'd1 > last_c) ? last_c : p15 + 15'd1;
		idx3 = (p15 + 15'd2 > last_c) ? last_c : p15 + 15'd2;
		unique case (tap_q[1:0])
			2'd0: idx = idx0;
			2'd1: idx = idx1;
			2'd2: idx = idx2;
			default: idx = idx3;
		endcase
	end

	assign raddr = MW'(MW'({lay_q[slot_q], ch_q}) * MW'(LAYER_DEPTH)) + MW'(idx);

	hlcr_sample_mem #(.DEPTH(DEPTH), .AW(MW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(sample_value),
		.raddr(raddr), .rdata(rdata)
	);

	// ---------------------------------------------------------------- hermite
	herm_req_t hreq;
	logic hdone;
	herm_t hval;
	taps_t y_in;

	assign hreq.start = (state_q == S_READ) && (tap_q == 3'd4);
	assign hreq.frac = f_q;

	// last tap comes straight from the memory on the start cycle
	always_comb begin
		y_in = y_q;
		y_in[3] = rdata;
	end

	hlcr_hermite u_herm (
		.clk(clk), .arst_n(arst_n), .req(hreq), .y(y_in), .done(hdone), .h(hval)
	);

	// ---------------------------------------------------------------- mix
	logic signed [HW+3:0] v;
	logic signed [15:0] sat_v;
	herm_t m0, m1;

	assign m0 = mix_ch_q ? hr_q[0] : hl_q[0];
	assign m1 = mix_ch_q ? hr_q[1] : hl_q[1];
	assign v = (HW+4)'((g_q + (HW+32)'(64'sd134217728)) >>> 28);

	always_comb begin
		if (v > (HW+4)'(32767)) begin
			sat_v = 16'sh7FFF;
		end else if (v < -(HW+4)'(32768)) begin
			sat_v = -16'sh8000;
		end else begin
			sat_v = v[15:0];
		end
	end

	logic [30:0] phase_sum;
	assign phase_sum = {1'b0, phase_q} + 31'(pitch_step_q);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			playing_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_START: begin
								phase_q <= '0;
								playing_q <= 1'b1;
							end
							CMD_KILL: playing_q <= 1'b0;
							CMD_TICK: begin
								if (playing_q && (n != '0)) begin
									lay_q[0] <= li;
									lay_q[1] <= lj;
									active_q <= {act_j, act_i};
									stereo_q[0] <= (li < 4'd4) && stereo_mask_q[li[1:0]];
									stereo_q[1] <= (lj < 4'd4) && stereo_mask_q[lj[1:0]];
									last_q[0] <= len_i - 15'd1;
									last_q[1] <= len_j - 15'd1;
									a_q <= la;
									pos_q <= phase_q[29:16];
									f_q <= phase_q[15:0];
									gain_q <= gain;
									rel_q <= release_over;
									slot_q <= 1'b0;
									mix_ch_q <= 1'b0;
									if (!act_i && !act_j) begin
										res_l_q <= '0;
										res_r_q <= '0;
										res_fin_q <= 1'b1;
										upd_q <= 1'b0;
										state_q <= S_OUT;
									end else begin
										upd_q <= 1'b1;
										state_q <= S_SLOT;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_SLOT: begin
					ch_q <= 1'b0;
					tap_q <= '0;
					if (active_q[slot_q]) begin
						state_q <= S_READ;
					end else begin
						hl_q[slot_q] <= '0;
						hr_q[slot_q] <= '0;
						if (slot_q) begin
							state_q <= S_MUL;
						end else begin
							slot_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					if (tap_q != 3'd0) begin
						y_q[tap_q[1:0] - 2'd1] <= rdata;
					end
					if (tap_q == 3'd4) begin
						state_q <= S_HERM;
					end else begin
						tap_q <= tap_q + 3'd1;
					end
				end
				S_HERM: begin
					if (hdone) begin
						tap_q <= '0;
						if (!ch_q) begin
							hl_q[slot_q] <= hval;
							hr_q[slot_q] <= hval;
						end else begin
							hr_q[slot_q] <= hval;
						end
						if (!ch_q && stereo_q[slot_q]) begin
							ch_q <= 1'b1;
							state_q <= S_READ;
						end else if (slot_q) begin
							state_q <= S_MUL;
						end else begin
							slot_q <= 1'b1;
							state_q <= S_SLOT;
						end
					end
				end
				S_MUL: begin
					p0_q <= (HW+14)'(m0 * $signed({1'b0, 13'd4096 - {1'b0, a_q}}));
					p1_q <= (HW+14)'(m1 * $signed({1'b0, a_q}));
					state_q <= S_SUM;
				end
				S_SUM: begin
					s_q <= (HW+15)'(p0_q) + (HW+15)'(p1_q);
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					g_q <= (HW+32)'(s_q * $signed({1'b0, gain_q}));
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (!mix_ch_q) begin
						res_l_q <= sat_v;
						mix_ch_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						res_r_q <= sat_v;
						res_fin_q <= rel_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for the output register to free up
					if (!out_valid_q || !out_stall) begin
						left_out <= res_l_q;
						right_out <= res_r_q;
						finished <= res_fin_q;
						out_valid_q <= 1'b1;
						if (upd_q) begin
							phase_q <= phase_sum[30] ? 30'h3FFF_FFFF : phase_sum[29:0];
						end
						if (res_fin_q) begin
							playing_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
